// ----- rtl/dzp_pkg.sv -----
// ----------------------------------------------------------------------------
// dzp_pkg
// Shared constants, level tables and types of the delta zigzag prefix encoder.
// ----------------------------------------------------------------------------
package dzp_pkg;

  localparam int MAX_CHANNELS = 3;
  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  localparam int SAMPLE_W = 8;
  localparam int VAL_W    = 7;
  localparam int CNT_W    = 3;
  localparam int CHIDX_W  = 2;
  localparam int CFG_W    = 2;
  localparam int CODE_W   = 11;
  localparam int ACC_W    = VAL_W + CODE_W;
  localparam int NBYTES   = 3;
  localparam int NUM_W    = 2;

  // Prefix code, prefix length, data length and base of each level.
  localparam logic [2:0] LVL_PREFIX     [4] = '{3'b000, 3'b010, 3'b110, 3'b111};
  localparam logic [1:0] LVL_PREFIX_LEN [4] = '{2'd1, 2'd2, 2'd3, 2'd3};
  localparam logic [3:0] LVL_DATA_LEN   [4] = '{4'd1, 4'd2, 4'd4, 4'd8};
  localparam logic [7:0] LVL_BASE       [4] = '{8'd0, 8'd2, 8'd6, 8'd22};

  // Bytes produced by one sample, held until the output side has sent them.
  typedef struct packed {
    logic [NBYTES-1:0][7:0] bytes;
    logic [NUM_W-1:0]       num;
    logic                   img_end;
  } dzp_packet_t;

endpackage

// ----- rtl/dzp_encode.sv -----
// ----------------------------------------------------------------------------
// dzp_encode
// Codes one halved sample against its channel predecessor and packs the code
// bits behind the pending bits into up to three bytes.
// ----------------------------------------------------------------------------
module dzp_encode (
  input  logic [dzp_pkg::VAL_W-1:0] cur,
  input  logic [dzp_pkg::VAL_W-1:0] prev,
  input  logic                      first,
  input  logic                      last,
  input  logic [dzp_pkg::VAL_W-1:0] pend,
  input  logic [dzp_pkg::CNT_W-1:0] cnt,
  output dzp_pkg::dzp_packet_t      pkt,
  output logic [dzp_pkg::VAL_W-1:0] pend_next,
  output logic [dzp_pkg::CNT_W-1:0] cnt_next
);

  logic [7:0]                   z;
  logic [1:0]                   lvl;
  logic [3:0]                   dlen;
  logic [7:0]                   zdata;
  logic [dzp_pkg::CODE_W-1:0]   code;
  logic [3:0]                   len;
  logic [dzp_pkg::ACC_W-1:0]    acc;
  logic [4:0]                   total;
  logic [1:0]                   nfull;
  logic [4:0]                   rem_wide;
  logic [dzp_pkg::CNT_W-1:0]    rem;
  logic [dzp_pkg::VAL_W-1:0]    rem_bits;
  logic [dzp_pkg::ACC_W-1:0]    b0_wide;
  logic [dzp_pkg::ACC_W-1:0]    b1_wide;
  logic [7:0]                   b0;
  logic [7:0]                   b1;
  logic [7:0]                   flush_byte;
  logic                         do_flush;
  logic [1:0]                   n_main;

  always_comb begin
    if (cur >= prev) begin
      z = {cur - prev, 1'b0};
    end else begin
      z = {prev - cur, 1'b0} - 8'd1;
    end

    if (z >= dzp_pkg::LVL_BASE[3]) begin
      lvl = 2'd3;
    end else if (z >= dzp_pkg::LVL_BASE[2]) begin
      lvl = 2'd2;
    end else if (z >= dzp_pkg::LVL_BASE[1]) begin
      lvl = 2'd1;
    end else begin
      lvl = 2'd0;
    end

    dlen  = dzp_pkg::LVL_DATA_LEN[lvl];
    zdata = (z - dzp_pkg::LVL_BASE[lvl]) & ~(8'hFF << dlen);
    code  = ({8'd0, dzp_pkg::LVL_PREFIX[lvl]} << dlen) | {3'd0, zdata};
    len   = {2'd0, dzp_pkg::LVL_PREFIX_LEN[lvl]} + dlen;
    acc   = ({11'd0, pend} << len) | {7'd0, code};
    total = {2'd0, cnt} + {1'b0, len};

    if (total >= 5'd16) begin
      nfull = 2'd2;
    end else if (total >= 5'd8) begin
      nfull = 2'd1;
    end else begin
      nfull = 2'd0;
    end

    b0_wide  = acc >> (total - 5'd8);
    b1_wide  = acc >> (total - 5'd16);
    b0       = b0_wide[7:0];
    b1       = b1_wide[7:0];
    rem_wide = total - {nfull, 3'd0};

    // The raw first-pixel byte leaves the pending bits as they are.
    if (first) begin
      rem      = cnt;
      rem_bits = pend;
      n_main   = 2'd1;
    end else begin
      rem      = rem_wide[dzp_pkg::CNT_W-1:0];
      rem_bits = acc[dzp_pkg::VAL_W-1:0] & ~(7'h7F << rem);
      n_main   = nfull;
    end

    do_flush   = last && (rem != '0);
    flush_byte = {1'b0, rem_bits} << (4'd8 - {1'b0, rem});

    pkt.bytes[0] = first ? {1'b0, cur} : ((nfull != 2'd0) ? b0 : flush_byte);
    pkt.bytes[1] = (!first && nfull == 2'd2) ? b1 : flush_byte;
    pkt.bytes[2] = flush_byte;
    pkt.num      = n_main + {1'b0, do_flush};
    pkt.img_end  = last;

    pend_next = last ? '0 : rem_bits;
    cnt_next  = last ? '0 : rem;
  end

endmodule

// ----- rtl/dzp_out_buf.sv -----
// ----------------------------------------------------------------------------
// dzp_out_buf
// Result register: holds the bytes of one sample and sends them one per
// transfer on the output stream.
// ----------------------------------------------------------------------------
module dzp_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  dzp_pkg::dzp_packet_t pkt,
  output logic                 can_load,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,
  output logic                 m_tlast,
  output logic                 m_tuser
);

  logic                           valid;
  logic [dzp_pkg::NUM_W-1:0]      idx;
  logic [dzp_pkg::NUM_W-1:0]      num;
  logic [dzp_pkg::NBYTES-1:0][7:0] bytes;
  logic                           img_end;
  logic                           at_last;
  logic                           done;

  assign at_last  = (idx == num - 2'd1);
  assign done     = valid && m_tready && at_last;
  assign can_load = !valid || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (can_load) begin
      valid <= load;
      idx   <= '0;
    end else if (m_tready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      bytes   <= pkt.bytes;
      num     <= pkt.num;
      img_end <= pkt.img_end;
    end
  end

  assign m_tvalid = valid;
  assign m_tdata  = bytes[idx];
  assign m_tlast  = at_last;
  assign m_tuser  = at_last && img_end;

endmodule

// ----- rtl/delta_zigzag_prefix_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// delta_zigzag_prefix_encoder_unit
// Delta, zigzag and prefix-code image encoder with a byte-wide output stream.
// ----------------------------------------------------------------------------
// Samples enter on the s_ stream, one 8-bit sample per transfer with tlast set
// on the final sample of an image. Coded bytes leave on the m_ stream: tlast
// marks the last byte caused by one sample, tuser the last byte of the image.
// A sample may cause no byte at all when its code bits stay pending.
// The cfg channel sets the channel count (1 grey, 3 RGB); it is always ready
// and is to be written only between images while the block is empty.
// An accepted sample is held in an input register and coded in one pass into
// the result register, from which its first byte goes out on m_tdata. The
// result register sends one byte per cycle while m_tready is high. A new
// sample is taken while the last byte of the previous one is being sent.
// When the receiver stalls the result register holds its byte, the input
// register fills, and s_tready falls until the stall ends.
// Reset empties both registers, sets the channel count to 1 and starts a new
// image with a raw first pixel.
// ----------------------------------------------------------------------------
module delta_zigzag_prefix_encoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] sample
  input  logic                          s_tlast,   // last_sample
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [7:0] out_byte
  output logic                          m_tlast,   // end_of_run
  output logic                          m_tuser,   // [0] end_of_image
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dzp_pkg::CFG_W-1:0]     cfg_data   // [1:0] channel_count
);

  logic                              in_valid;
  logic [dzp_pkg::SAMPLE_W-1:0]      in_sample;
  logic                              in_last;
  logic [dzp_pkg::CFG_W-1:0]         channel_count;
  logic [dzp_pkg::VAL_W-1:0]         prev_sample [dzp_pkg::MAX_CHANNELS];
  logic [dzp_pkg::CHIDX_W-1:0]       channel_index;
  logic                              in_first_pixel;
  logic [dzp_pkg::VAL_W-1:0]         pending_bits;
  logic [dzp_pkg::CNT_W-1:0]         pending_count;

  logic [dzp_pkg::CHIDX_W-1:0]       nch;
  logic [dzp_pkg::CHIDX_W-1:0]       ch;
  logic [dzp_pkg::CHIDX_W:0]         ch_inc;
  logic [dzp_pkg::VAL_W-1:0]         cur;
  logic [dzp_pkg::VAL_W-1:0]         pend_next;
  logic [dzp_pkg::CNT_W-1:0]         cnt_next;
  dzp_pkg::dzp_packet_t              pkt;
  logic                              can_load;
  logic                              move;

  assign cfg_ready = 1'b1;
  assign move      = in_valid && can_load;
  assign s_tready  = !in_valid || move;
  assign cur       = in_sample[dzp_pkg::SAMPLE_W-1:1];

  always_comb begin
    if (channel_count == '0) begin
      nch = dzp_pkg::CHIDX_W'(1);
    end else if ({1'b0, channel_count} > 3'(dzp_pkg::MAX_CHANNELS)) begin
      nch = dzp_pkg::CHIDX_W'(dzp_pkg::MAX_CHANNELS);
    end else begin
      nch = channel_count;
    end
    // A stale index, left by a mid-image register write, restarts at zero.
    ch     = (channel_index >= nch) ? '0 : channel_index;
    ch_inc = {1'b0, ch} + 3'd1;
  end

  dzp_encode u_encode (
    .cur       (cur),
    .prev      (prev_sample[ch[dzp_pkg::CH_W-1:0]]),
    .first     (in_first_pixel),
    .last      (in_last),
    .pend      (pending_bits),
    .cnt       (pending_count),
    .pkt       (pkt),
    .pend_next (pend_next),
    .cnt_next  (cnt_next)
  );

  dzp_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (move && (pkt.num != '0)),
    .pkt      (pkt),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      channel_count  <= dzp_pkg::CFG_W'(1);
      channel_index  <= '0;
      in_first_pixel <= 1'b1;
      pending_bits   <= '0;
      pending_count  <= '0;
      for (int i = 0; i < dzp_pkg::MAX_CHANNELS; i++) begin
        prev_sample[i] <= '0;
      end
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (cfg_valid) begin
        channel_count <= cfg_data;
      end
      if (move) begin
        prev_sample[ch[dzp_pkg::CH_W-1:0]] <= cur;
        pending_bits  <= pend_next;
        pending_count <= cnt_next;
        if (in_last) begin
          in_first_pixel <= 1'b1;
          channel_index  <= '0;
        end else if (ch_inc >= {1'b0, nch}) begin
          in_first_pixel <= 1'b0;
          channel_index  <= '0;
        end else begin
          channel_index <= ch_inc[dzp_pkg::CHIDX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sample <= s_tdata;
      in_last   <= s_tlast;
    end
  end

endmodule

// ----- rtl/dzp_checker.sv -----
// ----------------------------------------------------------------------------
// dzp_checker
// Port-level checks of the encoder's input and output streams, bound to the top level.
// ----------------------------------------------------------------------------
module dzp_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);

  // The end of an image is always the end of a sample's bytes.
  a_img_end_is_run_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("end_of_image without end_of_run");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid straight after reset");

  // The input only backs up behind a byte that is waiting to leave.
  a_backpressure_needs_output: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |-> m_tvalid)
    else $error("input stalled with an empty output");

  // The output only empties after the final byte of a sample has gone.
  a_drop_after_run_end: assert property (@(posedge clk) disable iff (rst)
    $fell(m_tvalid) && $past(!rst) |-> $past(m_tlast && m_tready))
    else $error("output emptied before the end of a run");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

endmodule

bind delta_zigzag_prefix_encoder_unit dzp_checker u_dzp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// ----- test/dzp_stream_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dzp_stream_checker
// Watches the sample, byte and setting channels of the encoder, predicts the
// coded byte stream and compares every byte that leaves the block.
// ----------------------------------------------------------------------------
module dzp_stream_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [7:0]                s_tdata,
  input  logic                      s_tlast,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [7:0]                m_tdata,
  input  logic                      m_tlast,
  input  logic                      m_tuser,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [dzp_pkg::CFG_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        outstanding,
  output int                        bytes_checked
);

  localparam int NUM_CH     = dzp_pkg::MAX_CHANNELS;
  localparam int REPORT_MAX = 10;

  typedef enum int {LVL_TINY = 0, LVL_SHORT = 1, LVL_MID = 2, LVL_WIDE = 3} grade_e;

  localparam logic [2:0] LEAD_PATTERN [4] = '{3'b000, 3'b010, 3'b110, 3'b111};
  localparam int         PREFIX_BITS  [4] = '{1, 2, 3, 3};
  localparam int         DATA_BITS    [4] = '{1, 2, 4, 8};
  localparam int         GRADE_BASE   [4] = '{0, 2, 6, 22};

  typedef struct packed {
    logic [7:0] code_byte;
    logic       run_end;
    logic       img_end;
  } coded_byte_t;

  coded_byte_t expected_bytes [$];
  coded_byte_t want;

  // Encoder state as the predictor sees it.
  logic [6:0] last_val [NUM_CH];
  logic [1:0] chan_pos;
  bit         raw_pixel;
  logic [6:0] held_bits;
  int         held_cnt;
  logic [1:0] chan_setting;

  int errors  = 0;
  int checked = 0;

  function automatic int active_channels();
    int n;
    n = int'(chan_setting);
    if (n == 0) n = 1;
    if (n > NUM_CH) n = NUM_CH;
    return n;
  endfunction

  function automatic grade_e grade_of(int z);
    if (z >= GRADE_BASE[LVL_WIDE]) return LVL_WIDE;
    if (z >= GRADE_BASE[LVL_MID]) return LVL_MID;
    if (z >= GRADE_BASE[LVL_SHORT]) return LVL_SHORT;
    return LVL_TINY;
  endfunction

  // Works out the bytes that one sample releases and queues them.
  task automatic encode_sample(input logic [7:0] smp, input logic is_last);
    int          cur;
    int          prev;
    int          ch;
    int          z;
    int          dlen;
    int          len;
    int          n;
    int          cnt;
    int unsigned acc;
    int unsigned code;
    grade_e      g;
    logic [7:0]  out_b [3];
    cur = int'(smp[7:1]);
    ch  = int'(chan_pos);
    if (ch >= active_channels()) ch = 0;
    acc = 32'(held_bits);
    cnt = held_cnt;
    n   = 0;
    if (raw_pixel) begin
      out_b[n] = 8'(cur);
      n = n + 1;
    end else begin
      prev = int'(last_val[ch]);
      z    = (cur >= prev) ? 2 * (cur - prev) : 2 * (prev - cur) - 1;
      g    = grade_of(z);
      dlen = DATA_BITS[g];
      len  = PREFIX_BITS[g] + dlen;
      code = (int'(LEAD_PATTERN[g]) << dlen) | ((z - GRADE_BASE[g]) & ((1 << dlen) - 1));
      acc  = (acc << len) | code;
      cnt  = cnt + len;
      while (cnt >= 8) begin
        out_b[n] = 8'((acc >> (cnt - 8)) & 8'hFF);
        n   = n + 1;
        cnt = cnt - 8;
      end
      acc = acc & ((1 << cnt) - 1);
    end
    last_val[ch] = 7'(cur);
    if (is_last) begin
      // Flush the partial byte, padded with zeros on the right.
      if (cnt > 0) begin
        out_b[n] = 8'((acc << (8 - cnt)) & 8'hFF);
        n = n + 1;
      end
      acc       = 0;
      cnt       = 0;
      raw_pixel = 1'b1;
      chan_pos  = '0;
    end else begin
      ch = ch + 1;
      if (ch >= active_channels()) begin
        ch        = 0;
        raw_pixel = 1'b0;
      end
      chan_pos = 2'(ch);
    end
    held_bits = 7'(acc);
    held_cnt  = cnt;
    for (int k = 0; k < n; k++)
      expected_bytes.push_back('{out_b[k], k == n - 1, (k == n - 1) && is_last});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) last_val[i] = '0;
      chan_pos     = '0;
      raw_pixel    = 1'b1;
      held_bits    = '0;
      held_cnt     = 0;
      chan_setting = 2'd1;
      expected_bytes.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        checked = checked + 1;
        if (expected_bytes.size() == 0) begin
          errors = errors + 1;
          if (errors <= REPORT_MAX)
            $display("%0t: unexpected byte %02h tlast=%0b tuser=%0b", $realtime,
                     m_tdata, m_tlast, m_tuser);
        end else begin
          want = expected_bytes.pop_front();
          if (m_tdata !== want.code_byte || m_tlast !== want.run_end ||
              m_tuser !== want.img_end) begin
            errors = errors + 1;
            if (errors <= REPORT_MAX)
              $display("%0t: byte mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                       $realtime, want.code_byte, want.run_end, want.img_end,
                       m_tdata, m_tlast, m_tuser);
          end
        end
      end
      if (s_tvalid && s_tready) encode_sample(s_tdata, s_tlast);
      if (cfg_valid && cfg_ready) chan_setting = cfg_data;
    end
    outstanding   <= expected_bytes.size();
    fail_count    <= errors;
    bytes_checked <= checked;
  end

endmodule

// ----- test/delta_zigzag_prefix_encoder_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delta_zigzag_prefix_encoder_unit_test
// Drives images of grey, two-channel and RGB samples through the encoder with
// random gaps and stalls on both streams and lets the checker verify the bytes.
// ----------------------------------------------------------------------------
module delta_zigzag_prefix_encoder_unit_test;

  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 12;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_ITEMS  = 60;
  localparam int NUM_PHASES   = 6;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [7:0]                s_tdata   = '0;
  logic                      s_tlast   = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  logic [7:0]                m_tdata;
  logic                      m_tlast;
  logic                      m_tuser;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [dzp_pkg::CFG_W-1:0] cfg_data  = '0;

  int fail_count;
  int outstanding;
  int bytes_checked;

  int idle_cycles = 0;
  int items_sent  = 0;
  int images_sent = 0;

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_req  = 1'b0;

  // Stimulus-side view of the image, only used to shape smooth content.
  logic [1:0] setting = 2'd1;
  int         walk [3];
  int         tb_ch       = 0;
  bit         tb_raw      = 1'b1;

  delta_zigzag_prefix_encoder_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  dzp_stream_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .m_tuser       (m_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .bytes_checked (bytes_checked)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int active_channels();
    return (setting == 0) ? 1 : int'(setting);
  endfunction

  // Receiver: random ready pattern, a steady stretch on request and one long
  // hold-off while the sender keeps offering samples.
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_steady) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_sample(input logic [7:0] smp, input bit fin);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    items_sent = items_sent + 1;
    if (fin) images_sent = images_sent + 1;
    if (tb_ch >= active_channels()) tb_ch = 0;
    if (fin) begin
      tb_ch  = 0;
      tb_raw = 1'b1;
    end else begin
      tb_ch = tb_ch + 1;
      if (tb_ch >= active_channels()) begin
        tb_ch  = 0;
        tb_raw = 1'b0;
      end
    end
    gap = (tx_steady || hold_req) ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every expected byte has left and any sample that produced
  // none has passed through the pipeline.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(input logic [dzp_pkg::CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    setting = value;
  endtask

  // One image: a smooth random walk per channel, or plain noise.
  task automatic send_image(input int len, input bit smooth, input bit finish);
    int         ch;
    int         r;
    int         v;
    logic [7:0] smp;
    for (int i = 0; i < len; i++) begin
      ch = (tb_ch >= active_channels()) ? 0 : tb_ch;
      if (tb_raw || !smooth) begin
        v = $urandom_range(0, 255);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55)
          v = walk[ch] + $urandom_range(0, 8) - 4;
        else if (r < 85)
          v = walk[ch] + $urandom_range(0, 60) - 30;
        else
          v = $urandom_range(0, 255);
      end
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      walk[ch] = v;
      smp = 8'(v);
      smp[0] = 1'($urandom_range(0, 1));
      send_sample(smp, finish && (i == len - 1));
    end
  endtask

  initial begin
    logic [1:0] phase_setting [NUM_PHASES];
    int         phase_items;
    int         len;
    bit         finish;
    phase_setting = '{2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1};
    for (int i = 0; i < 3; i++) walk[i] = 128;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Grey: a one-sample image, then steps that land on each side of every
    // level threshold and the largest jumps in both directions.
    write_setting(2'd1);
    send_sample(8'h55, 1'b1);
    send_sample(8'd128, 1'b0);
    send_sample(8'd127, 1'b0);
    send_sample(8'd128, 1'b0);
    send_sample(8'd122, 1'b0);
    send_sample(8'd128, 1'b0);
    send_sample(8'd106, 1'b0);
    send_sample(8'd128, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd1, 1'b1);
    drain();

    // RGB image, then an unfinished one left with the channel index at 2.
    write_setting(2'd3);
    send_sample(8'hFF, 1'b0);
    send_sample(8'h00, 1'b0);
    send_sample(8'hAA, 1'b0);
    send_sample(8'h00, 1'b0);
    send_sample(8'hFF, 1'b0);
    send_sample(8'hAB, 1'b1);
    send_sample(8'h40, 1'b0);
    send_sample(8'h80, 1'b0);
    send_sample(8'hC0, 1'b0);
    send_sample(8'h42, 1'b0);
    send_sample(8'h7E, 1'b0);
    drain();

    // A count of zero acts as grey and the stale channel index restarts at 0.
    write_setting(2'd0);
    send_sample(8'hC3, 1'b0);
    send_sample(8'h3C, 1'b0);
    send_sample(8'h99, 1'b1);
    drain();

    write_setting(2'd2);
    send_sample(8'h10, 1'b0);
    send_sample(8'hF0, 1'b0);
    send_sample(8'h12, 1'b0);
    send_sample(8'hE0, 1'b1);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_setting(phase_setting[p]);
      tx_steady = (p == 2);
      rx_steady = (p == 2);
      if (p == 1) hold_req = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0:       len = 1;
          1:       len = $urandom_range(31, 70);
          default: len = $urandom_range(2, 30);
        endcase
        // The last image of a phase is sometimes left open across the write.
        finish = (phase_items + len < PHASE_ITEMS) || ($urandom_range(0, 9) > 2);
        send_image(len, $urandom_range(0, 99) < 85, finish);
        phase_items = phase_items + len;
      end
      drain();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    send_image(5, 1'b1, 1'b1);
    drain();

    $display("Run covered %0d samples in %0d closed images with channel settings 0 to 3,",
             items_sent, images_sent);
    $display("random gaps, one long receiver hold-off and %0d coded bytes checked.",
             bytes_checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d expected bytes missing", fail_count, outstanding);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/dzp_pkg.sv
rtl/dzp_encode.sv
rtl/dzp_out_buf.sv
rtl/delta_zigzag_prefix_encoder_unit.sv
rtl/dzp_checker.sv
test/dzp_stream_checker.sv
test/delta_zigzag_prefix_encoder_unit_test.sv
